// ===== design/vertex_dedup_indexer_macros.svh =====
// Assertion macros for the vertex dedup indexer.
// Used by the top level; needs nothing but a clk and rst_n in scope.
`ifndef VERTEX_DEDUP_INDEXER_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_MACROS_SVH
`ifndef SYNTHESIS
`define VDI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vdi check failed");
`define VDI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vdi check failed");
`else
`define VDI_ASSERT_SAME(label, ante, cons)
`define VDI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/vdi_pkg.sv =====
// Shared types, sizes and the float compare of the vertex dedup indexer.
// No dependencies.
`timescale 1ns / 1ps
package vdi_pkg;
  localparam int MAX_VERTICES = 256;
  localparam int FIELDS = 8;
  localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int COUNT_W = $clog2(MAX_VERTICES + 1);
  localparam int OUT_IDX_W = 8;

  typedef logic [31:0] vfield_t;
  typedef vfield_t [FIELDS-1:0] vertex_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] idx;
  } probe_t;

  // IEEE equality on single-precision bits: NaN never equal, +0 == -0.
  function automatic logic float_eq(vfield_t a, vfield_t b);
    logic [30:0] abs_a;
    logic [30:0] abs_b;
    logic        res;
    abs_a = a[30:0];
    abs_b = b[30:0];
    if (abs_a > 31'h7F80_0000 || abs_b > 31'h7F80_0000) begin
      res = 1'b0;
    end else if (abs_a == 31'd0 && abs_b == 31'd0) begin
      res = 1'b1;
    end else begin
      res = (a == b);
    end
    return res;
  endfunction
endpackage

// ===== design/vdi_cell.sv =====
// One table cell: holds a stored vertex, compares it with the query and
// passes the search probe on to the next cell. Depends on vdi_pkg.
`timescale 1ns / 1ps
module vdi_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [vdi_pkg::IDX_W-1:0]   cell_idx,
  input  logic [vdi_pkg::COUNT_W-1:0] count,
  input  vdi_pkg::vertex_t        query,
  input  logic                    wr_en,
  input  vdi_pkg::probe_t         probe_in,
  output vdi_pkg::probe_t         probe_out
);
  import vdi_pkg::*;

  vertex_t entry_r;
  probe_t  probe_r;
  probe_t  probe_nxt;
  logic    match;
  logic    live;

  always_comb begin
    match = 1'b1;
    for (int f = 0; f < FIELDS; f++) begin
      match = match & float_eq(entry_r[f], query[f]);
    end
  end

  assign live = COUNT_W'(cell_idx) < count;

  always_comb begin
    probe_nxt = probe_in;
    // claim the probe on the first live hit
    if (probe_in.valid && !probe_in.found && live && match) begin
      probe_nxt.found = 1'b1;
      probe_nxt.idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= query;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r.valid <= probe_nxt.valid;
    end
    probe_r.found <= probe_nxt.found;
    probe_r.idx   <= probe_nxt.idx;
  end

  assign probe_out = probe_r;
endmodule

// ===== design/vertex_dedup_indexer.sv =====
// Top level of the vertex dedup indexer: input capture, cell chain, commit.
// Depends on vdi_pkg, vdi_cell and vertex_dedup_indexer_macros.svh.
//
//  channel | ports                                  | beat
//  in      | in_valid/in_stall, in_first_of_mesh..  | one vertex
//  out     | out_valid/out_stall, out_vertex_index..| one index result
//
// The search probe of a beat walks the whole cell chain, one cell per cycle,
// then the result commits to the output. One vertex is in flight at a time;
// the next is taken once the previous result sits in the output register.
// Reset empties the table at once (the fill count drives cell liveness). A
// stalled output holds its beat.
`timescale 1ns / 1ps
`include "vertex_dedup_indexer_macros.svh"
module vertex_dedup_indexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_first_of_mesh,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_norm_x,
  input  logic [31:0] in_norm_y,
  input  logic [31:0] in_norm_z,
  input  logic [31:0] in_tex_u,
  input  logic [31:0] in_tex_v,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [vdi_pkg::OUT_IDX_W-1:0] out_vertex_index,
  output logic        out_is_new,
  output logic        out_table_full
);
  import vdi_pkg::*;

  logic               busy_r;
  logic               start_r;
  vertex_t            q_r;
  logic [COUNT_W-1:0] count_r;
  logic               res_v_r;
  logic               res_found_r;
  logic [IDX_W-1:0]   res_idx_r;
  logic               out_valid_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic               out_new_r;
  logic               out_full_r;

  logic   accept;
  logic   commit;
  logic   room;
  logic   append;
  probe_t probe_chain [0:MAX_VERTICES];

  assign accept = in_valid && !busy_r;
  assign in_stall = busy_r;
  assign commit = res_v_r && (!out_valid_r || !out_stall);
  assign room   = count_r < COUNT_W'(MAX_VERTICES);
  assign append = commit && !res_found_r && room;

  assign probe_chain[0] = '{valid: start_r, found: 1'b0, idx: '0};

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    vdi_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .count    (count_r),
      .query    (q_r),
      .wr_en    (append && (count_r == COUNT_W'(g))),
      .probe_in (probe_chain[g]),
      .probe_out(probe_chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r <= {in_tex_v, in_tex_u, in_norm_z, in_norm_y,
              in_norm_x, in_pos_z, in_pos_y, in_pos_x};
    end
    if (probe_chain[MAX_VERTICES].valid) begin
      res_found_r <= probe_chain[MAX_VERTICES].found;
      res_idx_r   <= probe_chain[MAX_VERTICES].idx;
    end
    if (commit) begin
      if (res_found_r) begin
        out_idx_r  <= OUT_IDX_W'(res_idx_r);
        out_new_r  <= 1'b0;
        out_full_r <= 1'b0;
      end else if (room) begin
        out_idx_r  <= OUT_IDX_W'(count_r);
        out_new_r  <= 1'b1;
        out_full_r <= 1'b0;
      end else begin
        out_idx_r  <= '0;
        out_new_r  <= 1'b0;
        out_full_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      count_r     <= '0;
      res_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= accept;
      if (accept) begin
        busy_r <= 1'b1;
        if (in_first_of_mesh) begin
          count_r <= '0;
        end
      end else if (commit) begin
        busy_r <= 1'b0;
      end
      if (append) begin
        count_r <= count_r + COUNT_W'(1);
      end
      // hold the chain result until the output register frees up
      if (probe_chain[MAX_VERTICES].valid) begin
        res_v_r <= 1'b1;
      end else if (commit) begin
        res_v_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_idx_r;
  assign out_is_new       = out_new_r;
  assign out_table_full   = out_full_r;

  `VDI_ASSERT_SAME(a_new_full_excl, out_valid_r, !(out_new_r && out_full_r))
  `VDI_ASSERT_SAME(a_full_idx_zero, out_valid_r && out_full_r, out_idx_r == '0)
  `VDI_ASSERT_SAME(a_probe_busy, probe_chain[MAX_VERTICES].valid, busy_r && !res_v_r)
  `VDI_ASSERT_NEXT(a_count_step, append, count_r == $past(count_r) + COUNT_W'(1))
endmodule
